// ===== src/timestamped_pose_interpolator_macros.svh =====
// assertion helpers used by the pose interpolator datapath
`ifndef TIMESTAMPED_POSE_INTERPOLATOR_MACROS_SVH
`define TIMESTAMPED_POSE_INTERPOLATOR_MACROS_SVH

// property checked on every clock while out of reset
`define TPI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen while out of reset
`define TPI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/tpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tpi_pkg
// types, constants and helpers of the timestamped pose interpolator
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    localparam logic [15:0] EXTRAP_RESET = 16'd200;
    localparam logic        ACT_ADD      = 1'b0;

    localparam logic signed [17:0] DEG180 = 18'sd23040;
    localparam logic signed [17:0] DEG360 = 18'sd46080;

    localparam int DMAG_W    = 24;
    localparam int NUM_W     = 32;
    localparam int PROD_W    = DMAG_W + NUM_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    typedef struct packed {
        logic signed [31:0] t;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] h;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        RD_OLDEST,
        RD_K,
        RD_K1
    } rd_sel_t;

    typedef enum logic [1:0] {
        MODE_TRIV,
        MODE_INTERP,
        MODE_EXTRAP
    } mode_t;

    typedef struct packed {
        logic    capture;
        logic    do_add;
        rd_sel_t rd_sel;
        logic    cap_a;
        logic    cap_b;
        logic    set_b_newest;
        logic    k_init;
        logic    k_dec;
        logic    set_mode;
        mode_t   mode;
        logic    lane_load;
        logic    lane_mul;
        logic    lane_div;
        logic    res_add;
        logic    res_empty;
        logic    res_lane;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic is_add;
        logic empty;
        logic single;
        logic before_old;
        logic after_new;
        logic k_zero;
        logic a_after_t;
        logic out_free;
    } status_t;

    // heading into [-180,180) degrees in units of 1/128 degree, input within two turns of the range
    function automatic logic signed [15:0] wrap_deg(input logic signed [17:0] v);
        logic signed [17:0] r;
        r = v;
        if (r >= DEG180) r = r - DEG360;
        if (r >= DEG180) r = r - DEG360;
        if (r < -DEG180) r = r + DEG360;
        if (r < -DEG180) r = r + DEG360;
        return r[15:0];
    endfunction

    // shortest way round between two headings
    function automatic logic signed [24:0] short_diff(input logic signed [16:0] d);
        logic signed [24:0] r;
        r = {{8{d[16]}}, d};
        if (r >= DEG180) r = r - DEG360;
        else if (r <= -DEG180) r = r + DEG360;
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [57:0] v);
        logic signed [23:0] r;
        if (v > 58'sd8388607) r = 24'sh7FFFFF;
        else if (v < -58'sd8388608) r = 24'sh800000;
        else r = v[23:0];
        return r;
    endfunction

endpackage

// ===== src/tpi_ram.sv =====
// ----------------------------------------------------------------------------
// tpi_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tpi_lane.sv =====
// ----------------------------------------------------------------------------
// tpi_lane
// one coordinate: base + delta * num / den, one quotient bit per step
// ----------------------------------------------------------------------------
module tpi_lane (
    input  logic               clk,
    input  logic               load,
    input  logic               mul,
    input  logic               div_step,
    input  logic signed [23:0] base,
    input  logic signed [24:0] delta,
    input  logic [31:0]        num,
    input  logic [31:0]        den,
    output logic signed [23:0] sat_out,
    output logic signed [15:0] wrap_out
);

    logic signed [23:0]        base_reg;
    logic                      neg_reg;
    logic [tpi_pkg::DMAG_W-1:0] dmag_reg;
    logic [tpi_pkg::NUM_W-1:0]  num_reg;
    logic [31:0]               den_reg;
    logic [tpi_pkg::PROD_W-1:0] prod_reg;
    logic [31:0]               rem_reg;
    logic [tpi_pkg::PROD_W-1:0] q_reg;
    logic [15:0]               qm_reg;

    logic [24:0]               dabs;
    logic [32:0]               trial;
    logic                      qbit;
    logic [31:0]               rem_next;
    logic [16:0]               qm2;
    logic [15:0]               qm_next;
    logic signed [57:0]        qs;
    logic signed [57:0]        xv;
    logic signed [17:0]        hv;

    assign dabs     = delta[24] ? 25'(-delta) : 25'(delta);
    assign trial    = {rem_reg, prod_reg[tpi_pkg::PROD_W-1]};
    assign qbit     = trial >= {1'b0, den_reg};
    assign rem_next = qbit ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
    // quotient kept modulo a full turn as well, for the heading lane
    assign qm2      = {qm_reg, qbit};
    assign qm_next  = (qm2 >= 17'(tpi_pkg::DEG360)) ? 16'(qm2 - 17'(tpi_pkg::DEG360))
                                                    : qm2[15:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            base_reg <= base;
            neg_reg  <= delta[24];
            dmag_reg <= dabs[23:0];
            num_reg  <= num;
            den_reg  <= den;
        end
        if (mul)
        begin
            prod_reg <= dmag_reg * num_reg;
            rem_reg  <= '0;
            q_reg    <= '0;
            qm_reg   <= '0;
        end
        else if (div_step)
        begin
            prod_reg <= {prod_reg[tpi_pkg::PROD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            q_reg    <= {q_reg[tpi_pkg::PROD_W-2:0], qbit};
            qm_reg   <= qm_next;
        end
    end

    assign qs       = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
    assign xv       = {{34{base_reg[23]}}, base_reg} + qs;
    assign hv       = neg_reg ? base_reg[17:0] - $signed({2'b00, qm_reg})
                              : base_reg[17:0] + $signed({2'b00, qm_reg});
    assign sat_out  = tpi_pkg::sat24(xv);
    assign wrap_out = tpi_pkg::wrap_deg(hv);

endmodule

// ===== src/tpi_datapath.sv =====
// ----------------------------------------------------------------------------
// tpi_datapath
// history ram, item and entry registers, three arithmetic lanes, output stage
// ----------------------------------------------------------------------------
`include "timestamped_pose_interpolator_macros.svh"

module tpi_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                action,
    input  logic signed [31:0]  event_time,
    input  logic signed [23:0]  pos_x,
    input  logic signed [23:0]  pos_y,
    input  logic signed [15:0]  heading,
    input  logic                cfg_wen,
    input  logic [15:0]         cfg_wdata,
    input  logic                out_stall,
    input  tpi_pkg::cmd_t       cmd,
    output tpi_pkg::status_t    status,
    output logic                out_valid,
    output logic                ok,
    output logic signed [23:0]  out_x,
    output logic signed [23:0]  out_y,
    output logic signed [15:0]  out_heading
);

    logic                        action_reg;
    logic signed [31:0]          time_reg;
    logic signed [23:0]          x_reg;
    logic signed [23:0]          y_reg;
    logic signed [15:0]          h_reg;
    logic [15:0]                 limit_reg;
    logic [tpi_pkg::CNT_W-1:0]   count_reg;
    logic [tpi_pkg::SLOT_W-1:0]  newest_slot_reg;
    tpi_pkg::entry_t             newest_reg;
    tpi_pkg::entry_t             a_reg;
    tpi_pkg::entry_t             b_reg;
    logic [tpi_pkg::SLOT_W-1:0]  k_reg;
    tpi_pkg::mode_t              mode_reg;
    logic                        res_ok_reg;
    logic signed [23:0]          res_x_reg;
    logic signed [23:0]          res_y_reg;
    logic signed [15:0]          res_h_reg;
    logic                        out_valid_reg;
    logic                        ok_reg;
    logic signed [23:0]          ox_reg;
    logic signed [23:0]          oy_reg;
    logic signed [15:0]          oh_reg;

    logic                        add_ok;
    logic [tpi_pkg::SLOT_W-1:0]  wslot;
    logic [tpi_pkg::SLOT_W+1:0]  oldest_sum;
    logic [tpi_pkg::SLOT_W-1:0]  oldest;
    logic [tpi_pkg::SLOT_W:0]    sum_k;
    logic [tpi_pkg::SLOT_W:0]    sum_k1;
    logic [tpi_pkg::SLOT_W-1:0]  slot_k;
    logic [tpi_pkg::SLOT_W-1:0]  slot_k1;
    logic [tpi_pkg::SLOT_W-1:0]  raddr;
    tpi_pkg::entry_t             rdata;
    tpi_pkg::entry_t             wdata;

    logic signed [32:0]          t33;
    logic signed [32:0]          at33;
    logic signed [32:0]          bt33;
    logic signed [32:0]          cap33;
    logic signed [32:0]          q33;
    logic signed [32:0]          n_int33;
    logic signed [32:0]          n_ext33;
    logic signed [32:0]          den33;
    logic signed [24:0]          dx;
    logic signed [24:0]          dy;
    logic signed [24:0]          dh;

    logic signed [23:0]          l_bx;
    logic signed [23:0]          l_by;
    logic signed [23:0]          l_bh;
    logic signed [24:0]          l_dx;
    logic signed [24:0]          l_dy;
    logic signed [24:0]          l_dh;
    logic [31:0]                 l_num;
    logic [31:0]                 l_den;
    logic signed [23:0]          lx_out;
    logic signed [23:0]          ly_out;
    logic signed [15:0]          lh_out;

    assign add_ok = (count_reg == '0) || (time_reg > newest_reg.t);
    assign wslot  = (count_reg == '0) ? '0
                  : (newest_slot_reg == tpi_pkg::SLOT_W'(tpi_pkg::HISTORY_DEPTH - 1)) ? '0
                  : tpi_pkg::SLOT_W'(newest_slot_reg + 1'b1);

    // oldest slot sits count-1 places behind the newest, around the ring
    assign oldest_sum = (tpi_pkg::SLOT_W+2)'(newest_slot_reg)
                      + (tpi_pkg::SLOT_W+2)'(tpi_pkg::HISTORY_DEPTH)
                      - (tpi_pkg::SLOT_W+2)'(count_reg - 1'b1);
    assign oldest = (oldest_sum >= (tpi_pkg::SLOT_W+2)'(tpi_pkg::HISTORY_DEPTH))
                  ? tpi_pkg::SLOT_W'(oldest_sum - (tpi_pkg::SLOT_W+2)'(tpi_pkg::HISTORY_DEPTH))
                  : oldest_sum[tpi_pkg::SLOT_W-1:0];

    assign sum_k   = (tpi_pkg::SLOT_W+1)'(oldest) + (tpi_pkg::SLOT_W+1)'(k_reg);
    assign sum_k1  = sum_k + 1'b1;
    assign slot_k  = (sum_k >= (tpi_pkg::SLOT_W+1)'(tpi_pkg::HISTORY_DEPTH))
                   ? tpi_pkg::SLOT_W'(sum_k - (tpi_pkg::SLOT_W+1)'(tpi_pkg::HISTORY_DEPTH))
                   : sum_k[tpi_pkg::SLOT_W-1:0];
    assign slot_k1 = (sum_k1 >= (tpi_pkg::SLOT_W+1)'(tpi_pkg::HISTORY_DEPTH))
                   ? tpi_pkg::SLOT_W'(sum_k1 - (tpi_pkg::SLOT_W+1)'(tpi_pkg::HISTORY_DEPTH))
                   : sum_k1[tpi_pkg::SLOT_W-1:0];

    always_comb
    begin
        case (cmd.rd_sel)
            tpi_pkg::RD_OLDEST: raddr = oldest;
            tpi_pkg::RD_K:      raddr = slot_k;
            tpi_pkg::RD_K1:     raddr = slot_k1;
            default:            raddr = oldest;
        endcase
    end

    assign wdata = '{t: time_reg, x: x_reg, y: y_reg, h: h_reg};

    tpi_ram #(
        .WIDTH (tpi_pkg::ENTRY_W),
        .DEPTH (tpi_pkg::HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.do_add && add_ok),
        .waddr (wslot),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // lane operands
    assign t33     = {time_reg[31], time_reg};
    assign at33    = {a_reg.t[31], a_reg.t};
    assign bt33    = {b_reg.t[31], b_reg.t};
    assign cap33   = bt33 + $signed({17'b0, limit_reg});
    assign q33     = (t33 > cap33) ? cap33 : t33;
    assign n_int33 = t33 - at33;
    assign n_ext33 = q33 - bt33;
    assign den33   = bt33 - at33;
    assign dx      = {b_reg.x[23], b_reg.x} - {a_reg.x[23], a_reg.x};
    assign dy      = {b_reg.y[23], b_reg.y} - {a_reg.y[23], a_reg.y};
    assign dh      = tpi_pkg::short_diff({b_reg.h[15], b_reg.h} - {a_reg.h[15], a_reg.h});

    always_comb
    begin
        case (mode_reg)
            tpi_pkg::MODE_INTERP:
            begin
                l_bx  = a_reg.x;
                l_by  = a_reg.y;
                l_bh  = {{8{a_reg.h[15]}}, a_reg.h};
                l_dx  = dx;
                l_dy  = dy;
                l_dh  = dh;
                l_num = n_int33[31:0];
                l_den = den33[31:0];
            end
            tpi_pkg::MODE_EXTRAP:
            begin
                l_bx  = b_reg.x;
                l_by  = b_reg.y;
                l_bh  = {{8{b_reg.h[15]}}, b_reg.h};
                l_dx  = dx;
                l_dy  = dy;
                l_dh  = dh;
                l_num = n_ext33[31:0];
                l_den = den33[31:0];
            end
            default:
            begin
                l_bx  = a_reg.x;
                l_by  = a_reg.y;
                l_bh  = {{8{a_reg.h[15]}}, a_reg.h};
                l_dx  = '0;
                l_dy  = '0;
                l_dh  = '0;
                l_num = '0;
                l_den = 32'd1;
            end
        endcase
    end

    tpi_lane u_lane_x (
        .clk      (clk),
        .load     (cmd.lane_load),
        .mul      (cmd.lane_mul),
        .div_step (cmd.lane_div),
        .base     (l_bx),
        .delta    (l_dx),
        .num      (l_num),
        .den      (l_den),
        .sat_out  (lx_out),
        .wrap_out ()
    );

    tpi_lane u_lane_y (
        .clk      (clk),
        .load     (cmd.lane_load),
        .mul      (cmd.lane_mul),
        .div_step (cmd.lane_div),
        .base     (l_by),
        .delta    (l_dy),
        .num      (l_num),
        .den      (l_den),
        .sat_out  (ly_out),
        .wrap_out ()
    );

    tpi_lane u_lane_h (
        .clk      (clk),
        .load     (cmd.lane_load),
        .mul      (cmd.lane_mul),
        .div_step (cmd.lane_div),
        .base     (l_bh),
        .delta    (l_dh),
        .num      (l_num),
        .den      (l_den),
        .sat_out  (),
        .wrap_out (lh_out)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            time_reg   <= event_time;
            x_reg      <= pos_x;
            y_reg      <= pos_y;
            h_reg      <= heading;
        end
        if (cmd.do_add && add_ok)
        begin
            newest_reg <= wdata;
        end
        if (cmd.cap_a)
        begin
            a_reg <= rdata;
        end
        if (cmd.cap_b)
        begin
            b_reg <= rdata;
        end
        else if (cmd.set_b_newest)
        begin
            b_reg <= newest_reg;
        end
        if (cmd.k_init)
        begin
            k_reg <= tpi_pkg::SLOT_W'(count_reg - 2'd2);
        end
        else if (cmd.k_dec)
        begin
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.set_mode)
        begin
            mode_reg <= cmd.mode;
        end
        if (cmd.res_add)
        begin
            res_ok_reg <= add_ok;
            res_x_reg  <= '0;
            res_y_reg  <= '0;
            res_h_reg  <= '0;
        end
        else if (cmd.res_empty)
        begin
            res_ok_reg <= 1'b0;
            res_x_reg  <= '0;
            res_y_reg  <= '0;
            res_h_reg  <= '0;
        end
        else if (cmd.res_lane)
        begin
            res_ok_reg <= 1'b1;
            res_x_reg  <= lx_out;
            res_y_reg  <= ly_out;
            res_h_reg  <= lh_out;
        end
        if (cmd.out_load)
        begin
            ok_reg <= res_ok_reg;
            ox_reg <= res_x_reg;
            oy_reg <= res_y_reg;
            oh_reg <= res_h_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= tpi_pkg::EXTRAP_RESET;
            count_reg       <= '0;
            newest_slot_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.do_add && add_ok)
            begin
                newest_slot_reg <= wslot;
                if (count_reg < tpi_pkg::CNT_W'(tpi_pkg::HISTORY_DEPTH))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.is_add     = (action_reg == tpi_pkg::ACT_ADD);
    assign status.empty      = (count_reg == '0);
    assign status.single     = (count_reg == tpi_pkg::CNT_W'(1));
    assign status.before_old = (time_reg < a_reg.t);
    assign status.after_new  = (time_reg >= newest_reg.t);
    assign status.k_zero     = (k_reg == '0);
    assign status.a_after_t  = (a_reg.t > time_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_heading = oh_reg;

    `TPI_NEVER(a_count_bound, count_reg > tpi_pkg::CNT_W'(tpi_pkg::HISTORY_DEPTH), "history count beyond depth")
    `TPI_ASSERT(a_newest_time, (cmd.do_add && add_ok) |=> (newest_reg.t == $past(time_reg)), "newest time not taken from accepted add")
    `TPI_NEVER(a_out_overrun, cmd.out_load && out_valid_reg && out_stall, "result loaded over a stalled item")

endmodule

// ===== src/tpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpi_ctrl
// sequencer for add, history walk, lane load and division steps
// ----------------------------------------------------------------------------
module tpi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tpi_pkg::status_t status,
    output tpi_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_OLD_WT,
        S_OLD_DEC,
        S_P_RD,
        S_P_WT,
        S_W_RD,
        S_W_WT,
        S_W_DEC,
        S_N_RD,
        S_N_WT,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_RES,
        S_DONE
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [tpi_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [tpi_pkg::DIV_CNT_W-1:0] div_cnt_next;

    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = tpi_pkg::RD_OLDEST;
        cmd.mode     = tpi_pkg::MODE_TRIV;
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.is_add)
                begin
                    cmd.do_add  = 1'b1;
                    cmd.res_add = 1'b1;
                    state_next  = S_DONE;
                end
                else if (status.empty)
                begin
                    cmd.res_empty = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = tpi_pkg::RD_OLDEST;
                    state_next = S_OLD_WT;
                end
            end
            S_OLD_WT:
            begin
                cmd.cap_a  = 1'b1;
                state_next = S_OLD_DEC;
            end
            S_OLD_DEC:
            begin
                cmd.set_mode = 1'b1;
                if (status.single || status.before_old)
                begin
                    cmd.mode   = tpi_pkg::MODE_TRIV;
                    state_next = S_LOAD;
                end
                else if (status.after_new)
                begin
                    cmd.mode         = tpi_pkg::MODE_EXTRAP;
                    cmd.set_b_newest = 1'b1;
                    cmd.k_init       = 1'b1;
                    state_next       = S_P_RD;
                end
                else
                begin
                    cmd.mode   = tpi_pkg::MODE_INTERP;
                    cmd.k_init = 1'b1;
                    state_next = S_W_RD;
                end
            end
            S_P_RD:
            begin
                cmd.rd_sel = tpi_pkg::RD_K;
                state_next = S_P_WT;
            end
            S_P_WT:
            begin
                cmd.cap_a  = 1'b1;
                state_next = S_LOAD;
            end
            S_W_RD:
            begin
                cmd.rd_sel = tpi_pkg::RD_K;
                state_next = S_W_WT;
            end
            S_W_WT:
            begin
                cmd.cap_a  = 1'b1;
                state_next = S_W_DEC;
            end
            S_W_DEC:
            begin
                // step back until the entry is not later than the query time or k reaches zero
                if (!status.k_zero && status.a_after_t)
                begin
                    cmd.k_dec  = 1'b1;
                    state_next = S_W_RD;
                end
                else
                begin
                    state_next = S_N_RD;
                end
            end
            S_N_RD:
            begin
                cmd.rd_sel = tpi_pkg::RD_K1;
                state_next = S_N_WT;
            end
            S_N_WT:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.lane_load = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.lane_mul = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.lane_div = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == tpi_pkg::DIV_CNT_W'(tpi_pkg::PROD_W - 1))
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                cmd.res_lane = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== src/timestamped_pose_interpolator.sv =====
// an add or a query on empty history goes straight to the output stage; a query
//   with a single entry or a time before the oldest runs the lanes, extrapolation
//   first reads the entry before the newest and interpolation walks back entry by entry
// queries use the single registered history ram read port and the 56-step divider
// one item at a time; the next item is taken the cycle after the result is loaded
// rst_n clears the sequencer, history count, newest slot, output valid and limit (200)
// ----------------------------------------------------------------------------
// timestamped_pose_interpolator
// pose history ring with linear interpolation and capped extrapolation
// ----------------------------------------------------------------------------
module timestamped_pose_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [31:0] event_time,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic signed [23:0] out_x,
    output logic signed [23:0] out_y,
    output logic signed [15:0] out_heading,
    input  logic               cfg_wen,
    input  logic [15:0]        cfg_wdata
);

    tpi_pkg::cmd_t    cmd;
    tpi_pkg::status_t status;

    tpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tpi_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .event_time  (event_time),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .ok          (ok),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_heading (out_heading)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// pose interpolator check: adds and queries driven with random gaps and
// stalls, each result compared against an in-bench pose history model
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH       = tpi_pkg::HISTORY_DEPTH;
    localparam int WDOG_LIMIT  = 5000;
    localparam int SETTLE_CYC  = 300;
    localparam int MAX_REPORTS = 10;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct {
        logic        ok;
        logic [23:0] x;
        logic [23:0] y;
        logic [15:0] h;
    } pose_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic signed [31:0] event_time;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] heading;
    logic               out_valid;
    logic               out_stall;
    logic               ok;
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [15:0] out_heading;
    logic               cfg_wen;
    logic [15:0]        cfg_wdata;

    // pose history model
    longint      hist_t [DEPTH];
    longint      hist_x [DEPTH];
    longint      hist_y [DEPTH];
    longint      hist_h [DEPTH];
    int unsigned hist_cnt;
    int unsigned hist_newest;
    longint      extrap_limit;

    pose_result_t expected_poses[$];
    int  mismatches;
    int  idle_cycles;
    bit  idle_on;
    longint tcur;

    timestamped_pose_interpolator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .event_time(event_time),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .out_x(out_x), .out_y(out_y), .out_heading(out_heading),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // value as the port of width w sees it
    function automatic longint sign_ext(input longint v, input int w);
        longint m;
        m = (longint'(1) << w) - 1;
        v = v & m;
        if (v[w-1]) return v - (longint'(1) << w);
        return v;
    endfunction

    function automatic longint wrap_angle(input longint v);
        longint r;
        r = v % 46080;
        if (r < 0) r += 46080;
        if (r >= 23040) r -= 46080;
        return r;
    endfunction

    function automatic longint shortest_turn(input longint d);
        if (d >= 23040) return d - 46080;
        if (d <= -23040) return d + 46080;
        return d;
    endfunction

    function automatic longint clamp24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint lerp(input longint a, input longint d, input longint n,
                                    input longint den);
        if (den <= 0) return a;
        return a + (d * n) / den;
    endfunction

    function automatic pose_result_t predict_pose(input logic act, input longint t,
                                                  input longint x, input longint y,
                                                  input longint h);
        pose_result_t r;
        int unsigned  s, oldest, k, a, b, p;
        longint       ox, oy, oh, n, den, cap, q;
        t = sign_ext(t, 32);
        x = sign_ext(x, 24);
        y = sign_ext(y, 24);
        h = sign_ext(h, 16);
        ox = 0; oy = 0; oh = 0;
        r.ok = 1'b0;
        if (act == tpi_pkg::ACT_ADD) begin
            if (hist_cnt == 0 || t > hist_t[hist_newest]) begin
                s = (hist_cnt == 0) ? 0 : (hist_newest + 1) % DEPTH;
                hist_t[s] = t; hist_x[s] = x; hist_y[s] = y; hist_h[s] = h;
                hist_newest = s;
                if (hist_cnt < DEPTH) hist_cnt++;
                r.ok = 1'b1;
            end
        end else if (hist_cnt != 0) begin
            oldest = (hist_newest + DEPTH - (hist_cnt - 1)) % DEPTH;
            r.ok = 1'b1;
            if (hist_cnt == 1 || t < hist_t[oldest]) begin
                ox = hist_x[oldest]; oy = hist_y[oldest]; oh = hist_h[oldest];
            end else if (t < hist_t[hist_newest]) begin
                k = hist_cnt - 2;
                a = (oldest + k) % DEPTH;
                while (k > 0 && hist_t[a] > t) begin
                    k--;
                    a = (oldest + k) % DEPTH;
                end
                b = (oldest + k + 1) % DEPTH;
                n = t - hist_t[a];
                den = hist_t[b] - hist_t[a];
                ox = lerp(hist_x[a], hist_x[b] - hist_x[a], n, den);
                oy = lerp(hist_y[a], hist_y[b] - hist_y[a], n, den);
                oh = lerp(hist_h[a], shortest_turn(hist_h[b] - hist_h[a]), n, den);
            end else begin
                p = (oldest + hist_cnt - 2) % DEPTH;
                cap = hist_t[hist_newest] + extrap_limit;
                q = (t > cap) ? cap : t;
                n = q - hist_t[hist_newest];
                den = hist_t[hist_newest] - hist_t[p];
                ox = lerp(hist_x[hist_newest], hist_x[hist_newest] - hist_x[p], n, den);
                oy = lerp(hist_y[hist_newest], hist_y[hist_newest] - hist_y[p], n, den);
                oh = lerp(hist_h[hist_newest],
                          shortest_turn(hist_h[hist_newest] - hist_h[p]), n, den);
            end
            ox = clamp24(ox);
            oy = clamp24(oy);
            oh = wrap_angle(oh);
        end
        r.x = ox[23:0];
        r.y = oy[23:0];
        r.h = oh[15:0];
        return r;
    endfunction

    // one item on the input channel, valid left high after acceptance
    task automatic send_item(input logic act, input longint t, input longint x,
                             input longint y, input longint h);
        int gap;
        pose_result_t exp_r;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        action     = act;
        event_time = t[31:0];
        pos_x      = x[23:0];
        pos_y      = y[23:0];
        heading    = h[15:0];
        in_valid   = 1'b1;
        do @(posedge clk); while (in_stall);
        exp_r = predict_pose(act, t, x, y, h);
        expected_poses.insert(expected_poses.size(), exp_r);
        @(negedge clk);
    endtask

    task automatic add_pose(input longint t, input longint x, input longint y,
                            input longint h);
        send_item(tpi_pkg::ACT_ADD, t, x, y, h);
    endtask

    task automatic query_pose(input longint t);
        send_item(ACT_QUERY, t, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_poses.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_limit(input int unsigned v);
        wait_drained();
        cfg_wdata = v[15:0];
        cfg_wen   = 1'b1;
        @(negedge clk);
        cfg_wen   = 1'b0;
        extrap_limit = v;
    endtask

    // output side stall, one draw per result
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = idle_on ? $urandom_range(0, 10) : 0;
            out_stall = (n > 0);
            repeat (n) @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        pose_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result ok=%0d x=%0d y=%0d h=%0d",
                             ok, out_x, out_y, out_heading);
            end else begin
                e = expected_poses.pop_front();
                if (ok !== e.ok || out_x !== e.x || out_y !== e.y || out_heading !== e.h)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch exp ok=%0d x=%0d y=%0d h=%0d got ok=%0d x=%0d y=%0d h=%0d",
                                 e.ok, $signed(e.x), $signed(e.y), $signed(e.h),
                                 ok, out_x, out_y, out_heading);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_empty_history();
        idle_on = 1'b0;
        query_pose(0);
        query_pose(-2147483648);
        add_pose(-2147483648, 8388607, -8388608, -23040);
        query_pose(2147483647);
        query_pose(-2147483648);
        add_pose(-2147483648, 1, 1, 1);
    endtask

    task automatic test_directed();
        idle_on = 1'b1;
        add_pose(100, 25600, -25600, 23000);
        add_pose(100, 0, 0, 0);
        add_pose(50, 0, 0, 0);
        add_pose(200, -25600, 25600, -23000);
        query_pose(50);
        query_pose(100);
        query_pose(150);
        query_pose(199);
        query_pose(200);
        query_pose(260);
        query_pose(100000);
        // stored headings beyond half a turn
        add_pose(300, 8388607, -8388608, 32767);
        add_pose(400, -8388608, 8388607, -32768);
        query_pose(350);
        query_pose(5000);
        add_pose(500, 8388607, -8388608, 23039);
        query_pose(700);
        tcur = 500;
    endtask

    task automatic run_random_items(input int count);
        int  sel;
        longint t;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                tcur += $urandom_range(1, 60);
                t = (sel < 5) ? $signed(24'($urandom)) : $urandom_range(0, 4000) - 2000;
                add_pose(tcur, t * 64 + $urandom_range(0, 255), $signed(24'($urandom)),
                         (sel % 8 == 0) ? $signed(16'($urandom))
                                        : longint'($urandom_range(0, 46079)) - 23040);
            end else if (sel < 88) begin
                query_pose(tcur - longint'($urandom_range(0, 4000)) + 300);
            end else if (sel < 94) begin
                add_pose(tcur - longint'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            end else begin
                query_pose($signed(32'($urandom)));
            end
        end
    endtask

    task automatic test_random();
        idle_on = 1'b1;
        run_random_items(480);
        write_limit(0);
        run_random_items(480);
        write_limit(65535);
        idle_on = 1'b0;
        run_random_items(300);
        idle_on = 1'b1;
        run_random_items(200);
        write_limit($urandom_range(1, 65534));
        run_random_items(480);
    endtask

    task automatic test_time_extremes();
        write_limit(65535);
        add_pose(2147483647, -8388608, 8388607, 0);
        add_pose(2147483647, 0, 0, 0);
        query_pose(2147483647);
        query_pose(2147483646);
        query_pose(-2147483648);
    endtask

    initial
    begin
        rst_n = 1'b0; in_valid = 1'b0; action = tpi_pkg::ACT_ADD; event_time = '0;
        pos_x = '0; pos_y = '0; heading = '0; cfg_wen = 1'b0; cfg_wdata = '0;
        idle_on = 1'b0; mismatches = 0; idle_cycles = 0;
        hist_cnt = 0; hist_newest = 0; extrap_limit = 200; tcur = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_empty_history();
        test_directed();
        test_random();
        test_time_extremes();
        wait_drained();
        if (mismatches == 0 && expected_poses.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
